// File: hdl/tpwm_pkg.sv
// Shared types and constants for the two-channel 8-bit PWM timer.
package tpwm_pkg;

    localparam int unsigned COUNT_W = 8;
    localparam int unsigned DIV_W   = 10;

    localparam logic [COUNT_W-1:0] CNT_MAX = 8'hFF;
    localparam logic [COUNT_W-1:0] CNT_MIN = 8'h00;

    // Item kinds
    localparam logic [1:0] OP_TICK  = 2'h0;
    localparam logic [1:0] OP_WRITE = 2'h1;
    localparam logic [1:0] OP_READ  = 2'h2;

    // Clock select codes
    localparam logic [2:0] CS_STOP    = 3'h0;
    localparam logic [2:0] CS_DIV1    = 3'h1;
    localparam logic [2:0] CS_DIV8    = 3'h2;
    localparam logic [2:0] CS_DIV64   = 3'h3;
    localparam logic [2:0] CS_DIV256  = 3'h4;
    localparam logic [2:0] CS_DIV1024 = 3'h5;

    // Register index, taken from paddr[2]
    localparam logic REG_PWM_MODE = 1'b0;
    localparam logic REG_CLK_SEL  = 1'b1;

    localparam logic MODE_FAST  = 1'b0;
    localparam logic MODE_PHASE = 1'b1;

    typedef struct packed {
        logic [1:0]         mode;
        logic               channel;
        logic [COUNT_W-1:0] write_data;
    } t_in_word;

    typedef struct packed {
        logic               out_a;
        logic               out_b;
        logic [COUNT_W-1:0] count_value;
        logic [COUNT_W-1:0] read_data;
    } t_out_word;

    // What the counter did on this item
    typedef struct packed {
        logic               advance;
        logic               rising;
        logic               load;
        logic [COUNT_W-1:0] count;
    } t_cnt_evt;

endpackage

// File: hdl/tpwm_counter.sv
// Prescaler, 8-bit count and direction of the PWM timer.
module tpwm_counter (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_tick,
    input  logic              i_pwm_mode,
    input  logic [2:0]        i_clock_select,
    output tpwm_pkg::t_cnt_evt o_evt
);
    import tpwm_pkg::*;

    logic [DIV_W-1:0]   r_div;
    logic [DIV_W-1:0]   n_div;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic               r_down;
    logic               n_down;

    logic [DIV_W-1:0]   div_limit;
    logic               running;
    logic               step;
    logic [COUNT_W-1:0] step_count;

    // terminal prescaler value: divide ratio minus one
    always_comb begin
        running   = 1'b1;
        div_limit = '0;
        unique case (i_clock_select)
            CS_DIV1:    div_limit = DIV_W'(0);
            CS_DIV8:    div_limit = DIV_W'(7);
            CS_DIV64:   div_limit = DIV_W'(63);
            CS_DIV256:  div_limit = DIV_W'(255);
            CS_DIV1024: div_limit = DIV_W'(1023);
            default:    running   = 1'b0;   // stopped, and the unused codes
        endcase
    end

    always_comb begin
        n_div      = r_div;
        n_count    = r_count;
        n_down     = r_down;
        step       = 1'b0;
        step_count = r_count;
        o_evt      = '0;

        if (i_pwm_mode == MODE_PHASE) begin
            if (r_down) begin
                step_count = (r_count == CNT_MIN) ? COUNT_W'(1) : r_count - COUNT_W'(1);
            end else begin
                step_count = (r_count == CNT_MAX) ? CNT_MAX - COUNT_W'(1)
                                                  : r_count + COUNT_W'(1);
            end
        end else begin
            step_count = r_count + COUNT_W'(1);
        end

        if (i_tick && running) begin
            if (r_div >= div_limit) begin
                n_div = '0;
                step  = 1'b1;
            end else begin
                n_div = r_div + DIV_W'(1);
            end
        end

        o_evt.rising = step_count > r_count;
        if (step) begin
            n_count       = step_count;
            o_evt.advance = 1'b1;
            if (i_pwm_mode == MODE_PHASE) begin
                o_evt.load = (step_count == CNT_MAX);
                priority if (step_count == CNT_MAX) begin
                    n_down = 1'b1;
                end else if (step_count == CNT_MIN) begin
                    n_down = 1'b0;
                end else begin
                    n_down = !o_evt.rising;
                end
            end else begin
                o_evt.load = (step_count == CNT_MIN);
                n_down     = 1'b0;
            end
        end
        o_evt.count = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div   <= '0;
            r_count <= '0;
            r_down  <= 1'b0;
        end else begin
            r_div   <= n_div;
            r_count <= n_count;
            r_down  <= n_down;
        end
    end

endmodule

// File: hdl/timer_pwm_8bit_two_channel_core.sv
// Top level of the two-channel 8-bit PWM timer with compare buffering.
//
// Usage
//   Input words arrive on i_in_valid / i_in_word, held off by o_in_stall.
//   Each word is a clock tick, a compare write or a compare read for
//   channel A or B. Every accepted word yields exactly one result word on
//   o_out_valid / o_out_word: both pin levels, the count after the word,
//   and the buffered compare value on a read (zero otherwise).
//   The result is in the output register the cycle after acceptance.
//   Throughput is one word per cycle while the output is not stalled;
//   the update is one pass through the prescaler compare and count step.
//   When i_out_stall is high with a result waiting, o_in_stall rises and
//   the result holds until taken; a taken result frees the slot in the
//   same cycle, so back-to-back flow continues.
//   Reset (synchronous, active low) clears count, prescaler, direction,
//   compare buffers, active compares, pins and both registers; the output
//   register comes up empty.
//   APB registers: 0x0 pwm_mode (bit 0), 0x4 clock_select (bits 2:0).
//   Write them only while the timer is idle. pready is tied high.
module timer_pwm_8bit_two_channel_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input words
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  tpwm_pkg::t_in_word   i_in_word,
    // result words
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output tpwm_pkg::t_out_word  o_out_word,
    // register port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import tpwm_pkg::*;

    logic               r_pwm_mode;
    logic [2:0]         r_clk_sel;
    logic [COUNT_W-1:0] r_buf [2];
    logic [COUNT_W-1:0] n_buf [2];
    logic [COUNT_W-1:0] r_act [2];
    logic [COUNT_W-1:0] n_act [2];
    logic [1:0]         r_pin;
    logic [1:0]         n_pin;
    logic               r_out_valid;
    t_out_word          r_out_word;
    t_out_word          n_out_word;

    logic               in_take;
    logic               tick;
    logic               cfg_wr;
    t_cnt_evt           evt;

    assign pready      = 1'b1;
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign in_take     = i_in_valid & ~o_in_stall;
    assign tick        = in_take && (i_in_word.mode == OP_TICK);
    assign cfg_wr      = psel & penable & pwrite & pready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // register readback
    always_comb begin
        unique case (paddr[2])
            REG_PWM_MODE: prdata = {31'b0, r_pwm_mode};
            REG_CLK_SEL:  prdata = {29'b0, r_clk_sel};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_mode <= MODE_FAST;
            r_clk_sel  <= CS_STOP;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_PWM_MODE) begin
                r_pwm_mode <= pwdata[0];
            end else begin
                r_clk_sel <= pwdata[2:0];
            end
        end
    end

    tpwm_counter u_counter (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tick         (tick),
        .i_pwm_mode     (r_pwm_mode),
        .i_clock_select (r_clk_sel),
        .o_evt          (evt)
    );

    // compare buffers, active compares and pin levels
    always_comb begin
        n_buf = r_buf;
        n_act = r_act;
        n_pin = r_pin;

        if (in_take && (i_in_word.mode == OP_WRITE)) begin
            n_buf[i_in_word.channel] = i_in_word.write_data;
        end

        if (evt.load) begin
            n_act = r_buf;
        end

        if (evt.advance) begin
            for (int ch = 0; ch < 2; ch++) begin
                if (r_pwm_mode == MODE_FAST) begin
                    n_pin[ch] = (evt.count <= n_act[ch]);
                end else begin
                    // phase-correct: bottom and top compares pin the level,
                    // otherwise the level only moves on a match
                    if (n_act[ch] == CNT_MIN) begin
                        n_pin[ch] = 1'b0;
                    end else if (n_act[ch] == CNT_MAX) begin
                        n_pin[ch] = 1'b1;
                    end else if (evt.count == n_act[ch]) begin
                        n_pin[ch] = !evt.rising;
                    end
                end
            end
        end

        n_out_word.out_a       = n_pin[0];
        n_out_word.out_b       = n_pin[1];
        n_out_word.count_value = evt.count;
        n_out_word.read_data   = (i_in_word.mode == OP_READ) ? r_buf[i_in_word.channel]
                                                              : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf       <= '{default: '0};
            r_act       <= '{default: '0};
            r_pin       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_buf <= n_buf;
            r_act <= n_act;
            r_pin <= n_pin;
            if (in_take) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded with each accepted word
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_out_word <= n_out_word;
        end
    end

endmodule

// File: hdl/tpwm_checker.sv
// Port-level assertions for the PWM timer, bound to the top level.
module tpwm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input tpwm_pkg::t_in_word  i_in_word,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input tpwm_pkg::t_out_word o_out_word
);
    import tpwm_pkg::*;

    // reset empties the result slot
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // every accepted word shows a result in the next cycle
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("accepted word gave no result");

    // only reads carry read data
    a_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_in_word.mode != OP_READ))
        |=> (o_out_word.read_data == '0))
        else $error("read data on a non-read word");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_word)))
        else $error("stalled result changed");

endmodule

bind timer_pwm_8bit_two_channel_core tpwm_checker u_tpwm_checker (.*);

// File: verif/tb.sv
// Self-checking testbench for the two-channel 8-bit PWM timer core.
`timescale 1ns / 1ps

module tb;

    import tpwm_pkg::*;

    // Word kind 3 is not decoded by the timer: no state change, plain status back
    localparam logic [1:0] OP_IDLE = 2'h3;
    // Clock select codes with no divider behind them; the timer treats them as stopped
    localparam logic [2:0] CS_SPARE6 = 3'h6;
    localparam logic [2:0] CS_SPARE7 = 3'h7;

    // Cycles with no word moving on either channel before the run is abandoned
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned PRINT_CAP      = 40;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    t_in_word    i_in_word   = '0;
    logic        i_out_stall = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;

    logic        o_in_stall;
    logic        o_out_valid;
    t_out_word   o_out_word;
    logic [31:0] prdata;
    logic        pready;

    timer_pwm_8bit_two_channel_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Timer predictor: mirrors the prescaler, counter, compare registers
    // and pin levels; stepped once per accepted input word.
    // ------------------------------------------------------------------
    logic [DIV_W-1:0]   pre_cnt;
    logic [COUNT_W-1:0] tmr_cnt;
    logic               tmr_down;
    logic [COUNT_W-1:0] ocr_buf [2];
    logic [COUNT_W-1:0] ocr_act [2];
    logic               pin_lvl [2];
    logic               cfg_mode;
    logic [2:0]         cfg_clk_sel;

    t_out_word   expected_words [$];
    t_out_word   want_word;
    int unsigned fail_count     = 0;
    int unsigned send_gap_pct   = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned quiet_cycles   = 0;

    task automatic model_reset();
        pre_cnt     = '0;
        tmr_cnt     = CNT_MIN;
        tmr_down    = 1'b0;
        cfg_mode    = MODE_FAST;
        cfg_clk_sel = CS_STOP;
        for (int ch = 0; ch < 2; ch++) begin
            ocr_buf[ch] = '0;
            ocr_act[ch] = '0;
            pin_lvl[ch] = 1'b0;
        end
    endtask

    function automatic int unsigned divisor(input logic [2:0] cs);
        case (cs)
            CS_DIV1:    return 1;
            CS_DIV8:    return 8;
            CS_DIV64:   return 64;
            CS_DIV256:  return 256;
            CS_DIV1024: return 1024;
            default:    return 0;   // stopped, and the two spare codes
        endcase
    endfunction

    task automatic load_compares();
        ocr_act[0] = ocr_buf[0];
        ocr_act[1] = ocr_buf[1];
    endtask

    // Fast mode: wrap 255 -> 0, load compares at the bottom, pin high while count <= compare
    task automatic step_fast();
        logic [COUNT_W-1:0] nxt;
        nxt      = tmr_cnt + 8'd1;
        tmr_down = 1'b0;
        if (nxt == CNT_MIN)
            load_compares();
        for (int ch = 0; ch < 2; ch++)
            pin_lvl[ch] = (nxt <= ocr_act[ch]);
        tmr_cnt = nxt;
    endtask

    // Phase-correct: bounce between 0 and 255, load at the top.
    // Compare 0 pins low, 255 pins high; otherwise clear on match rising, set falling.
    task automatic step_phase();
        logic [COUNT_W-1:0] nxt;
        logic               up;
        if (tmr_down)
            nxt = (tmr_cnt == CNT_MIN) ? 8'd1 : tmr_cnt - 8'd1;
        else
            nxt = (tmr_cnt == CNT_MAX) ? CNT_MAX - 8'd1 : tmr_cnt + 8'd1;
        up = (nxt > tmr_cnt);
        if (nxt == CNT_MAX)
            tmr_down = 1'b1;
        else if (nxt == CNT_MIN)
            tmr_down = 1'b0;
        else
            tmr_down = !up;
        if (nxt == CNT_MAX)
            load_compares();
        for (int ch = 0; ch < 2; ch++) begin
            if (ocr_act[ch] == CNT_MIN)
                pin_lvl[ch] = 1'b0;
            else if (ocr_act[ch] == CNT_MAX)
                pin_lvl[ch] = 1'b1;
            else if (nxt == ocr_act[ch])
                pin_lvl[ch] = !up;
        end
        tmr_cnt = nxt;
    endtask

    task automatic predict_word(input t_in_word w);
        t_out_word   r;
        int unsigned div;
        r = '0;
        case (w.mode)
            OP_TICK: begin
                div = divisor(cfg_clk_sel);
                if (div != 0) begin
                    if (pre_cnt >= div - 1) begin
                        pre_cnt = '0;
                        if (cfg_mode == MODE_PHASE)
                            step_phase();
                        else
                            step_fast();
                    end else begin
                        pre_cnt = pre_cnt + 1'b1;
                    end
                end
            end
            OP_WRITE: ocr_buf[w.channel] = w.write_data;
            OP_READ:  r.read_data = ocr_buf[w.channel];
            default: ;
        endcase
        r.out_a       = pin_lvl[0];
        r.out_b       = pin_lvl[1];
        r.count_value = tmr_cnt;
        expected_words.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Reporting, result checking and watchdog
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        fail_count++;
        if (fail_count <= PRINT_CAP)
            $display("ERROR @%0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
    endtask

    // Results are taken at the edge where valid is high and our stall is low;
    // the stall for the next cycle is rolled in the same block.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_words.size() == 0) begin
                report_mismatch("result word with nothing pending", 32'(o_out_word), 32'd0);
            end else begin
                want_word = expected_words.pop_front();
                if (o_out_word.out_a !== want_word.out_a)
                    report_mismatch("out_a", 32'(o_out_word.out_a), 32'(want_word.out_a));
                if (o_out_word.out_b !== want_word.out_b)
                    report_mismatch("out_b", 32'(o_out_word.out_b), 32'(want_word.out_b));
                if (o_out_word.count_value !== want_word.count_value)
                    report_mismatch("count_value", 32'(o_out_word.count_value),
                                    32'(want_word.count_value));
                if (o_out_word.read_data !== want_word.read_data)
                    report_mismatch("read_data", 32'(o_out_word.read_data),
                                    32'(want_word.read_data));
            end
        end
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Drivers. Every task is entered and left at a rising edge; valid is
    // left high after a word is taken so back-to-back words never see a
    // lower-then-raise in the same step.
    // ------------------------------------------------------------------
    task automatic send_word(input t_in_word w);
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        predict_word(w);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge i_clk);
    endtask

    // One APB transfer, setup then access. psel/penable are left up so that
    // transfers chain without a double assignment; the caller drops them.
    task automatic apb_access(input logic wr, input logic idx, input logic [31:0] data);
        logic [31:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (wr) begin
            if (idx == REG_PWM_MODE)
                cfg_mode = data[0];
            else
                cfg_clk_sel = data[2:0];
        end else begin
            want = (idx == REG_PWM_MODE) ? {31'b0, cfg_mode} : {29'b0, cfg_clk_sel};
            if (prdata !== want)
                report_mismatch(idx == REG_PWM_MODE ? "pwm_mode readback"
                                                    : "clock_select readback",
                                prdata, want);
        end
    endtask

    // Reprogram mode and clock select with junk in the unused bits, then read back
    task automatic set_timer(input logic mode, input logic [2:0] cs);
        logic [31:0] v_mode;
        logic [31:0] v_cs;
        v_mode      = $urandom;
        v_mode[0]   = mode;
        v_cs        = $urandom;
        v_cs[2:0]   = cs;
        wait_drained();
        apb_access(1'b1, REG_PWM_MODE, v_mode);
        apb_access(1'b1, REG_CLK_SEL,  v_cs);
        apb_access(1'b0, REG_PWM_MODE, '0);
        apb_access(1'b0, REG_CLK_SEL,  '0);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic t_in_word make_word(input logic [1:0] op, input logic ch,
                                           input logic [COUNT_W-1:0] data);
        t_in_word w;
        w.mode       = op;
        w.channel    = ch;
        w.write_data = data;
        return w;
    endfunction

    // Compare values biased towards the edge cases and the current count
    function automatic logic [COUNT_W-1:0] pick_compare();
        case ($urandom_range(6))
            0:       return CNT_MIN;
            1:       return CNT_MAX;
            2:       return 8'd1;
            3:       return CNT_MAX - 8'd1;
            4:       return tmr_cnt + 8'($urandom_range(12));
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic t_in_word random_word();
        int unsigned roll;
        t_in_word    w;
        roll         = $urandom_range(99);
        w.channel    = 1'($urandom);
        w.write_data = 8'($urandom);
        if (roll < 78) begin
            w.mode = OP_TICK;
        end else if (roll < 89) begin
            w.mode       = OP_WRITE;
            w.write_data = pick_compare();
        end else if (roll < 98) begin
            w.mode = OP_READ;
        end else begin
            w.mode = OP_IDLE;
        end
        return w;
    endfunction

    task automatic tick_word();
        send_word(make_word(OP_TICK, 1'($urandom), 8'($urandom)));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values, every word kind, stopped and spare clock selects, compare extremes
    task automatic test_directed();
        send_word(make_word(OP_READ,  1'b0, 8'hFF));
        send_word(make_word(OP_READ,  1'b1, 8'h00));
        tick_word();                                   // stopped clock: nothing moves
        send_word(make_word(OP_IDLE,  1'b0, 8'hA5));
        send_word(make_word(OP_WRITE, 1'b0, CNT_MAX));
        send_word(make_word(OP_WRITE, 1'b1, CNT_MIN));
        send_word(make_word(OP_READ,  1'b0, 8'h00));
        send_word(make_word(OP_READ,  1'b1, 8'hFF));
        set_timer(MODE_FAST, CS_DIV1);
        repeat (4) tick_word();                        // active compares still zero
        set_timer(MODE_FAST, CS_SPARE7);
        repeat (2) tick_word();
        set_timer(MODE_PHASE, CS_SPARE6);
        tick_word();
        set_timer(MODE_PHASE, CS_DIV1);
        repeat (3) tick_word();
        send_word(make_word(OP_WRITE, 1'b0, 8'd1));
        send_word(make_word(OP_WRITE, 1'b1, CNT_MAX - 8'd1));
        send_word(make_word(OP_READ,  1'b0, 8'h5A));
        send_word(make_word(OP_READ,  1'b1, 8'hA5));
        send_word(make_word(OP_IDLE,  1'b1, 8'hFF));
    endtask

    // Mode change at the top of a fast count, and phase -> fast while falling
    task automatic test_mode_switch();
        set_timer(MODE_FAST, CS_DIV1);
        while (tmr_cnt != CNT_MAX)
            tick_word();
        set_timer(MODE_PHASE, CS_DIV1);                // 255 while rising steps to 254
        repeat (20) tick_word();
        set_timer(MODE_FAST, CS_DIV1);                 // direction bit must drop
        repeat (10) tick_word();
    endtask

    task automatic run_setting(input logic mode, input logic [2:0] cs, input int unsigned n);
        set_timer(mode, cs);
        repeat (n) send_word(random_word());
    endtask

    // Mixed traffic over all divider settings; prescaler count carries over
    // from slower to faster settings so the wrap-on-overshoot path is hit.
    task automatic test_traffic(input int unsigned gap_pct, input int unsigned stall_pct);
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        run_setting(MODE_FAST,  CS_DIV1,    115);
        run_setting(MODE_PHASE, CS_DIV1,    180);
        run_setting(MODE_PHASE, CS_DIV64,    10);
        run_setting(MODE_FAST,  CS_DIV8,     30);
        run_setting(MODE_FAST,  CS_DIV256,    5);
        run_setting(MODE_PHASE, CS_DIV1024,   5);
        run_setting(MODE_PHASE, CS_STOP,      5);
    endtask

    initial begin
        model_reset();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_gap_pct   = 14;
        recv_stall_pct = 77;
        test_directed();
        test_mode_switch();
        test_traffic(14, 77);
        test_traffic(77, 14);
        test_traffic(0, 0);

        // Let the last results out, then allow the output register to settle
        wait_drained();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: sim.f
hdl/tpwm_pkg.sv
hdl/tpwm_counter.sv
hdl/timer_pwm_8bit_two_channel_core.sv
hdl/tpwm_checker.sv
verif/tb.sv
